### rtl/ring_strip_triangulator_defines.svh
// Assertion macros shared by the ring strip triangulator RTL.
`ifndef RING_STRIP_TRIANGULATOR_DEFINES_SVH
`define RING_STRIP_TRIANGULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSTRI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rstri same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSTRI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rstri next-cycle check failed");

`endif

### rtl/rstri_pkg.sv
// Shared constants and register map of the ring strip triangulator.
`default_nettype none
package rstri_pkg;

	// Default parameter values
	localparam int RING_MAX_DEF   = 4096;
	localparam int INDEX_BITS_DEF = 20;

	// Register field widths
	localparam int SIZE_W = 13;
	localparam int BASE_W = 20;

	// APB port widths
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Register word index (byte address / 4)
	typedef enum logic [1:0] {
		REG_OLD_SIZE = 2'd0,
		REG_NEW_SIZE = 2'd1,
		REG_OLD_BASE = 2'd2
	} reg_idx_t;

endpackage
`default_nettype wire

### rtl/rstri_remainder.sv
// Bit-serial restoring remainder unit: dividend mod divisor, one bit per cycle.
`default_nettype none
module rstri_remainder #(
	parameter int CNT_W = 12,
	parameter int SZ_W  = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [CNT_W-1:0] dividend,
	input  wire logic [SZ_W-1:0]  divisor,
	output logic                  busy,
	output logic                  done,
	output logic [CNT_W-1:0]      remainder
);

	localparam int STEP_W = $clog2(CNT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  num_q;
	logic [SZ_W-1:0]   rem_q;
	logic [SZ_W:0]     trial;
	logic [SZ_W:0]     diff;

	// Shift in the next dividend bit and try one subtraction
	always_comb begin
		trial = {rem_q, num_q[CNT_W-1]};
		diff  = trial - {1'b0, divisor};
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(CNT_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and dividend shift register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[SZ_W-1:0];
			end else begin
				rem_q <= trial[SZ_W-1:0];
			end
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign remainder = CNT_W'(rem_q);

endmodule
`default_nettype wire

### rtl/ring_strip_triangulator.sv
// Ring strip triangulator: zips a new vertex ring to the previous ring with triangles.
// The first triangle of a vertex is offered in the cycle after the vertex request is accepted.
// Throughput: one vertex request per cycle in, one triangle per cycle out; a vertex gives
//   one to three triangles, and a new request waits until the last of them is popped.
// A write to old_ring_size recomputes the old-ring position with a bit-serial remainder
//   unit; s_tready stays low from its registered start pulse through its done strobe.
// Reset (arst_n, asynchronous): ring counters cleared, sizes 1, base 0, output empty.
`default_nettype none
`include "ring_strip_triangulator_defines.svh"
module ring_strip_triangulator #(
	parameter int RING_MAX   = rstri_pkg::RING_MAX_DEF,
	parameter int INDEX_BITS = rstri_pkg::INDEX_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Vertex requests
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata,  // [0] ring_start
	// Triangles
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [((3*INDEX_BITS+7)/8)*8-1:0]      m_tdata,  // corner_a, corner_b, corner_c
	output logic                                   m_tlast,  // last_of_run
	// Configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [rstri_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [rstri_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [rstri_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                   pready
);

	localparam int CNT_W  = $clog2(RING_MAX);
	localparam int SZ_W   = $clog2(RING_MAX + 1);
	localparam int ACC_W  = 2 * CNT_W + 2;
	localparam int IDX_W  = INDEX_BITS;
	localparam int DATA_W = ((3 * INDEX_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] c;
		logic             last;
	} tri_t;

	// Configuration registers
	logic [rstri_pkg::SIZE_W-1:0] old_size_q;
	logic [rstri_pkg::SIZE_W-1:0] new_size_q;
	logic [rstri_pkg::BASE_W-1:0] old_base_q;
	logic                         cfg_wr;
	logic [1:0]                   reg_sel;
	logic                         start_q;

	// Ring state
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] pos_q;
	logic [ACC_W-1:0] ns_q;
	logic [ACC_W-1:0] os_q;

	// Result buffer, head in slot 0
	tri_t       slot_q [3];
	logic [1:0] cnt_q;

	// Remainder unit
	logic             mod_busy;
	logic             mod_done;
	logic [CNT_W-1:0] mod_rem;
	logic             recalc;

	// Per-request datapath
	logic [SZ_W-1:0]  m_eff;
	logic [SZ_W-1:0]  n_eff;
	logic             accept;
	logic             pop;
	logic             restart;
	logic [CNT_W-1:0] i0;
	logic [CNT_W-1:0] k0;
	logic [CNT_W-1:0] pos0;
	logic [ACC_W-1:0] ns0;
	logic [ACC_W-1:0] os0;
	logic             adv;
	logic [SZ_W-1:0]  pos_inc;
	logic [CNT_W-1:0] pos1;
	logic [CNT_W-1:0] k1;
	logic             ring_end;
	logic [SZ_W-1:0]  i_inc;
	logic [IDX_W-1:0] obase;
	logic [IDX_W-1:0] nbase;
	logic [IDX_W-1:0] cur;
	logic [IDX_W-1:0] nxt;
	tri_t             fan;
	tri_t             strip;
	tri_t             closing;
	tri_t             load [3];
	logic [1:0]       load_cnt;

	// APB access
	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		unique case (reg_sel)
			rstri_pkg::REG_OLD_SIZE: prdata = rstri_pkg::APB_DATA_W'(old_size_q);
			rstri_pkg::REG_NEW_SIZE: prdata = rstri_pkg::APB_DATA_W'(new_size_q);
			rstri_pkg::REG_OLD_BASE: prdata = rstri_pkg::APB_DATA_W'(old_base_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_size_q <= rstri_pkg::SIZE_W'(1);
			new_size_q <= rstri_pkg::SIZE_W'(1);
			old_base_q <= '0;
			start_q    <= 1'b0;
		end else begin
			start_q <= cfg_wr && (reg_sel == rstri_pkg::REG_OLD_SIZE);
			if (cfg_wr) begin
				unique case (reg_sel)
					rstri_pkg::REG_OLD_SIZE: old_size_q <= pwdata[rstri_pkg::SIZE_W-1:0];
					rstri_pkg::REG_NEW_SIZE: new_size_q <= pwdata[rstri_pkg::SIZE_W-1:0];
					rstri_pkg::REG_OLD_BASE: old_base_q <= pwdata[rstri_pkg::BASE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Clamp ring sizes to 1..RING_MAX
	always_comb begin
		if (old_size_q == '0) begin
			m_eff = SZ_W'(1);
		end else if (32'(old_size_q) > 32'(RING_MAX)) begin
			m_eff = SZ_W'(RING_MAX);
		end else begin
			m_eff = SZ_W'(old_size_q);
		end
		if (new_size_q == '0) begin
			n_eff = SZ_W'(1);
		end else if (32'(new_size_q) > 32'(RING_MAX)) begin
			n_eff = SZ_W'(RING_MAX);
		end else begin
			n_eff = SZ_W'(new_size_q);
		end
	end

	// Recompute the old-ring position after an old_ring_size write
	rstri_remainder #(
		.CNT_W (CNT_W),
		.SZ_W  (SZ_W)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.dividend  (k_q),
		.divisor   (m_eff),
		.busy      (mod_busy),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	assign recalc = start_q | mod_busy | mod_done;

	// Handshakes
	assign m_tvalid = (cnt_q != 2'd0);
	assign pop      = m_tvalid & m_tready;
	assign s_tready = !recalc && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready));
	assign accept   = s_tvalid & s_tready;

	// Triangles of one vertex
	always_comb begin
		restart = s_tdata[0] || (i_q == '0) || (SZ_W'(i_q) >= n_eff);
		i0      = restart ? '0 : i_q;
		k0      = restart ? '0 : k_q;
		pos0    = restart ? '0 : pos_q;
		ns0     = restart ? '0 : ns_q;
		os0     = restart ? ACC_W'(n_eff) : os_q;

		// Advance the old pointer when 2*i*m > (2k+1)*n
		adv     = (ns0 > os0);
		pos_inc = SZ_W'(pos0) + SZ_W'(1);
		if (!adv) begin
			pos1 = pos0;
		end else if (pos_inc >= m_eff) begin
			pos1 = '0;
		end else begin
			pos1 = CNT_W'(pos_inc);
		end
		k1 = k0 + CNT_W'(adv);

		i_inc    = SZ_W'(i0) + SZ_W'(1);
		ring_end = (i_inc >= n_eff);

		obase = IDX_W'(old_base_q);
		nbase = obase + IDX_W'(m_eff);
		cur   = nbase + IDX_W'(i0);
		nxt   = ring_end ? nbase : nbase + IDX_W'(i_inc);

		fan     = '{a: cur, b: obase + IDX_W'(pos0), c: obase + IDX_W'(pos1), last: 1'b0};
		strip   = '{a: cur, b: obase + IDX_W'(pos1), c: nxt, last: 1'b0};
		closing = '{a: obase + IDX_W'(m_eff - SZ_W'(1)), b: obase, c: nbase, last: 1'b0};

		// Pack the triangles from slot 0 and flag the final one
		load[0]  = adv ? fan : strip;
		load[1]  = adv ? strip : closing;
		load[2]  = closing;
		load_cnt = 2'd1 + 2'(adv) + 2'(ring_end);
		load[0].last = (load_cnt == 2'd1);
		load[1].last = (load_cnt == 2'd2);
		load[2].last = (load_cnt == 2'd3);
	end

	// Ring state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			k_q   <= '0;
			pos_q <= '0;
			ns_q  <= '0;
			os_q  <= '0;
		end else if (accept) begin
			if (ring_end) begin
				i_q   <= '0;
				k_q   <= '0;
				pos_q <= '0;
				ns_q  <= '0;
				os_q  <= '0;
			end else begin
				i_q   <= CNT_W'(i_inc);
				k_q   <= k1;
				pos_q <= pos1;
				ns_q  <= ns0 + (ACC_W'(m_eff) << 1);
				os_q  <= adv ? os0 + (ACC_W'(n_eff) << 1) : os0;
			end
		end else if (mod_done) begin
			pos_q <= mod_rem;
		end
	end

	// Result buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= load_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Result buffer payload: load on request, shift toward slot 0 on pop
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[0] <= load[0];
			slot_q[1] <= load[1];
			slot_q[2] <= load[2];
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

	assign m_tdata = DATA_W'({slot_q[0].c, slot_q[0].b, slot_q[0].a});
	assign m_tlast = slot_q[0].last;

	// Checks
	`RSTRI_ASSERT_NOW(a_no_req_in_recalc, clk, arst_n, s_tvalid && s_tready, !recalc)
	`RSTRI_ASSERT_NEXT(a_req_gives_result, clk, arst_n, s_tvalid && s_tready, m_tvalid)
	`RSTRI_ASSERT_NOW(a_last_matches_cnt, clk, arst_n, m_tvalid, m_tlast == (cnt_q == 2'd1))
	`RSTRI_ASSERT_NOW(a_pos_in_ring, clk, arst_n, !recalc, SZ_W'(pos_q) < m_eff)
	`RSTRI_ASSERT_NOW(a_k_not_past_i, clk, arst_n, 1'b1, k_q <= i_q)

endmodule
`default_nettype wire
